FILE: rtl/lrbr_pkg.sv
// Package for the line, rectangle and box rasterizer.
// Holds the field widths, register indexes, reset values and command codes.
// No dependencies; compiled first.
package lrbr_pkg;

    localparam int COLOR_BITS = 32;
    localparam int SIZE_BITS  = 13;

    typedef logic [SIZE_BITS-1:0]  size_t;
    typedef logic [COLOR_BITS-1:0] color_t;
    typedef logic [1:0]            kind_t;

    // Configuration register indexes.
    localparam logic REG_SURFACE_WIDTH  = 1'b0;
    localparam logic REG_SURFACE_HEIGHT = 1'b1;

    localparam size_t RESET_WIDTH  = 13'd480;
    localparam size_t RESET_HEIGHT = 13'd420;

    // Action codes.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Shape kinds.
    localparam kind_t KIND_LINE   = 2'd0;
    localparam kind_t KIND_RECT   = 2'd1;
    localparam kind_t KIND_BOX    = 2'd2;
    localparam kind_t KIND_UNUSED = 2'd3;

endpackage

FILE: rtl/lrbr_if.sv
// Valid/ready channel interfaces for the rasterizer command and pixel streams.
// Depends on lrbr_pkg for the color and kind widths.
interface lrbr_cmd_if #(
    parameter int COORD_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic                           action;
    lrbr_pkg::kind_t                shape_kind;
    logic signed [COORD_BITS-1:0]   x_start;
    logic signed [COORD_BITS-1:0]   y_start;
    logic signed [COORD_BITS-1:0]   x_end;
    logic signed [COORD_BITS-1:0]   y_end;
    lrbr_pkg::color_t               draw_color;

    modport source (
        output valid, action, shape_kind, x_start, y_start, x_end, y_end, draw_color,
        input  ready
    );
    modport sink (
        input  valid, action, shape_kind, x_start, y_start, x_end, y_end, draw_color,
        output ready
    );
endinterface

interface lrbr_pix_if #(
    parameter int COORD_BITS = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS-1:0]   pixel_x;
    logic signed [COORD_BITS-1:0]   pixel_y;
    lrbr_pkg::color_t               pixel_color;
    logic                           inside_res;
    logic                           last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, inside_res, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, inside_res, last,
        output ready
    );
endinterface

FILE: rtl/line_rect_box_rasterizer_core.sv
// Top level of the line, outline rectangle and filled box rasterizer.
// Depends on lrbr_pkg and on the lrbr_cmd_if and lrbr_pix_if channel interfaces.

// The core walks shapes with Bresenham's integer error term and hands out one
// pixel per step transaction. A start transaction (action 0) latches the shape
// kind, both corners and the color and produces no pixel; every following step
// transaction (action 1) produces exactly one pixel while a shape is active, and
// nothing once the shape has finished. A line runs from the first corner to the
// second; an outline rectangle is its four sides in order (top, right, bottom,
// left), so shared corners appear twice; a filled box is one horizontal line per
// row from y_start to y_end and is empty when y_start exceeds y_end. A start
// always abandons the shape in progress. Pixels are never clipped: each carries
// inside_res, set when 0 <= x < surface_width and 0 <= y < surface_height, and
// last marks the final pixel of the whole shape. The core accepts one command
// transaction per cycle; a pixel appears in the output register the cycle after
// its step is accepted. The rate is set by the combinational error-term update
// and segment reload loop. The output register
// lets a new command enter in the same cycle that the waiting pixel is taken;
// while a pixel sits in the register and is not taken, command transactions
// are held off. Configuration writes (index 0 surface width, index 1 surface
// height) should be made only while no pixel is pending.
module line_rect_box_rasterizer_core #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  lrbr_pkg::size_t                   cfg_data,
    lrbr_cmd_if.sink                          cmd,
    lrbr_pix_if.source                        pix
);

    // Error term needs headroom over the coordinate width: the span of two
    // corners takes one extra bit and doubling it for the compare one more.
    localparam int ERR_BITS = COORD_BITS + 3;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_RIGHT  = 2'd1;
    localparam logic [1:0] SIDE_BOTTOM = 2'd2;
    localparam logic [1:0] SIDE_LEFT   = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Configuration registers.
    lrbr_pkg::size_t surf_width_reg;
    lrbr_pkg::size_t surf_height_reg;

    // Shape control state.
    logic            busy_reg,    busy_next;
    lrbr_pkg::kind_t kind_reg,    kind_next;
    logic [1:0]      segment_reg, segment_next;

    // Shape payload state.
    coord_t              x1_reg, x1_next;
    coord_t              y1_reg, y1_next;
    coord_t              x2_reg, x2_next;
    coord_t              y2_reg, y2_next;
    lrbr_pkg::color_t    color_reg, color_next;
    coord_t              row_reg, row_next;

    // Bresenham walker state.
    coord_t                 cur_x_reg, cur_x_next;
    coord_t                 cur_y_reg, cur_y_next;
    coord_t                 end_x_reg, end_x_next;
    coord_t                 end_y_reg, end_y_next;
    logic [COORD_BITS-1:0]  adx_reg, adx_next;
    logic [COORD_BITS-1:0]  ady_reg, ady_next;
    logic                   neg_x_reg, neg_x_next;
    logic                   neg_y_reg, neg_y_next;
    logic signed [ERR_BITS-1:0] err_reg, err_next;

    // Output register.
    logic                pix_valid_reg, pix_valid_next;
    coord_t              pix_x_reg;
    coord_t              pix_y_reg;
    lrbr_pkg::color_t    pix_color_reg;
    logic                pix_inside_reg;
    logic                pix_last_reg;

    // Handshake and decision signals.
    logic cmd_fire;
    logic is_start;
    logic step_busy;
    logic at_end;
    logic rect_more;
    logic box_more;
    logic shape_done;
    logic inside_now;
    lrbr_pkg::kind_t start_kind;
    coord_t          row_inc;

    // Segment loader: endpoints chosen below, spans and signs computed here.
    logic   load_en;
    coord_t ld_xa, ld_ya, ld_xb, ld_yb;
    logic signed [COORD_BITS:0] ld_diff_x;
    logic signed [COORD_BITS:0] ld_diff_y;
    logic [COORD_BITS:0]        ld_neg_dx;
    logic [COORD_BITS:0]        ld_neg_dy;
    logic [COORD_BITS-1:0]      ld_adx;
    logic [COORD_BITS-1:0]      ld_ady;
    logic signed [ERR_BITS-1:0] ld_err;

    // Bresenham step.
    logic signed [ERR_BITS:0]   e2;
    logic signed [ERR_BITS:0]   e2_neg_dy;
    logic signed [ERR_BITS:0]   e2_dx;
    logic                       step_x;
    logic                       step_y;
    logic signed [ERR_BITS-1:0] err_dx;
    logic signed [ERR_BITS-1:0] err_dy;

    // A new command may enter whenever the output slot is free or draining.
    assign cmd.ready = !pix_valid_reg || pix.ready;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign is_start  = (cmd.action == lrbr_pkg::ACT_START);
    assign step_busy = cmd_fire && !is_start && busy_reg;

    assign start_kind = (cmd.shape_kind == lrbr_pkg::KIND_UNUSED) ?
                        lrbr_pkg::KIND_LINE : cmd.shape_kind;

    assign at_end    = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign rect_more = (kind_reg == lrbr_pkg::KIND_RECT) && (segment_reg != SIDE_LEFT);
    assign box_more  = (kind_reg == lrbr_pkg::KIND_BOX) && (row_reg < y2_reg);
    assign shape_done = at_end && !rect_more && !box_more;
    assign row_inc   = row_reg + coord_t'(1);

    // The inside test compares the signed coordinate against the unsigned
    // surface size after zero extension to a common width.
    assign inside_now =
        !cur_x_reg[COORD_BITS-1] && !cur_y_reg[COORD_BITS-1] &&
        ({{lrbr_pkg::SIZE_BITS{1'b0}}, cur_x_reg} < {{COORD_BITS{1'b0}}, surf_width_reg}) &&
        ({{lrbr_pkg::SIZE_BITS{1'b0}}, cur_y_reg} < {{COORD_BITS{1'b0}}, surf_height_reg});

    // Endpoint selection for whichever segment is loaded this cycle.
    always_comb
    begin
        load_en = 1'b0;
        ld_xa   = x1_reg;
        ld_ya   = y1_reg;
        ld_xb   = x2_reg;
        ld_yb   = y1_reg;
        if (cmd_fire && is_start)
        begin
            // Line: corner to corner; rectangle top side and first box row
            // both run along y_start.
            load_en = 1'b1;
            ld_xa   = cmd.x_start;
            ld_ya   = cmd.y_start;
            ld_xb   = cmd.x_end;
            ld_yb   = (start_kind == lrbr_pkg::KIND_LINE) ? cmd.y_end : cmd.y_start;
        end
        else if (step_busy && at_end && rect_more)
        begin
            load_en = 1'b1;
            case (segment_reg)
                SIDE_TOP:
                begin
                    ld_xa = x2_reg;
                    ld_ya = y1_reg;
                    ld_xb = x2_reg;
                    ld_yb = y2_reg;
                end
                SIDE_RIGHT:
                begin
                    ld_xa = x2_reg;
                    ld_ya = y2_reg;
                    ld_xb = x1_reg;
                    ld_yb = y2_reg;
                end
                SIDE_BOTTOM:
                begin
                    ld_xa = x1_reg;
                    ld_ya = y2_reg;
                    ld_xb = x1_reg;
                    ld_yb = y1_reg;
                end
                default:
                begin
                    ld_xa = x1_reg;
                    ld_ya = y1_reg;
                    ld_xb = x2_reg;
                    ld_yb = y1_reg;
                end
            endcase
        end
        else if (step_busy && at_end && box_more)
        begin
            load_en = 1'b1;
            ld_xa   = x1_reg;
            ld_ya   = row_inc;
            ld_xb   = x2_reg;
            ld_yb   = row_inc;
        end
    end

    assign ld_diff_x = {ld_xb[COORD_BITS-1], ld_xb} - {ld_xa[COORD_BITS-1], ld_xa};
    assign ld_diff_y = {ld_yb[COORD_BITS-1], ld_yb} - {ld_ya[COORD_BITS-1], ld_ya};
    assign ld_neg_dx = -ld_diff_x;
    assign ld_neg_dy = -ld_diff_y;
    assign ld_adx    = ld_diff_x[COORD_BITS] ? ld_neg_dx[COORD_BITS-1:0]
                                             : ld_diff_x[COORD_BITS-1:0];
    assign ld_ady    = ld_diff_y[COORD_BITS] ? ld_neg_dy[COORD_BITS-1:0]
                                             : ld_diff_y[COORD_BITS-1:0];
    assign ld_err    = $signed({3'b000, ld_adx}) - $signed({3'b000, ld_ady});

    // Classic Bresenham decision on twice the error term.
    assign e2        = {err_reg, 1'b0};
    assign e2_neg_dy = -$signed({4'b0000, ady_reg});
    assign e2_dx     = $signed({4'b0000, adx_reg});
    assign step_x    = e2 > e2_neg_dy;
    assign step_y    = e2 < e2_dx;
    assign err_dx    = step_y ? $signed({3'b000, adx_reg}) : '0;
    assign err_dy    = step_x ? $signed({3'b000, ady_reg}) : '0;

    always_comb
    begin
        busy_next    = busy_reg;
        kind_next    = kind_reg;
        segment_next = segment_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        x2_next      = x2_reg;
        y2_next      = y2_reg;
        color_next   = color_reg;
        row_next     = row_reg;
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        end_x_next   = end_x_reg;
        end_y_next   = end_y_reg;
        adx_next     = adx_reg;
        ady_next     = ady_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        err_next     = err_reg;

        if (cmd_fire && is_start)
        begin
            kind_next    = start_kind;
            x1_next      = cmd.x_start;
            y1_next      = cmd.y_start;
            x2_next      = cmd.x_end;
            y2_next      = cmd.y_end;
            color_next   = cmd.draw_color;
            segment_next = SIDE_TOP;
            row_next     = cmd.y_start;
            busy_next    = !((start_kind == lrbr_pkg::KIND_BOX) &&
                             (cmd.y_start > cmd.y_end));
        end
        else if (step_busy)
        begin
            if (!at_end)
            begin
                err_next = err_reg - err_dy + err_dx;
                if (step_x)
                begin
                    cur_x_next = neg_x_reg ? cur_x_reg - coord_t'(1) : cur_x_reg + coord_t'(1);
                end
                if (step_y)
                begin
                    cur_y_next = neg_y_reg ? cur_y_reg - coord_t'(1) : cur_y_reg + coord_t'(1);
                end
            end
            else if (rect_more)
            begin
                segment_next = segment_reg + 2'd1;
            end
            else if (box_more)
            begin
                row_next = row_inc;
            end
            else
            begin
                busy_next = 1'b0;
            end
        end

        if (load_en)
        begin
            cur_x_next = ld_xa;
            cur_y_next = ld_ya;
            end_x_next = ld_xb;
            end_y_next = ld_yb;
            adx_next   = ld_adx;
            ady_next   = ld_ady;
            neg_x_next = !(ld_xa < ld_xb);
            neg_y_next = !(ld_ya < ld_yb);
            err_next   = ld_err;
        end
    end

    always_comb
    begin
        if (step_busy)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surf_width_reg  <= lrbr_pkg::RESET_WIDTH;
            surf_height_reg <= lrbr_pkg::RESET_HEIGHT;
            busy_reg        <= 1'b0;
            kind_reg        <= lrbr_pkg::KIND_LINE;
            segment_reg     <= SIDE_TOP;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == lrbr_pkg::REG_SURFACE_WIDTH))
            begin
                surf_width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == lrbr_pkg::REG_SURFACE_HEIGHT))
            begin
                surf_height_reg <= cfg_data;
            end
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            segment_reg   <= segment_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Payload state, meaningful only while a shape is active.
    always_ff @(posedge clk)
    begin
        x1_reg    <= x1_next;
        y1_reg    <= y1_next;
        x2_reg    <= x2_next;
        y2_reg    <= y2_next;
        color_reg <= color_next;
        row_reg   <= row_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        end_x_reg <= end_x_next;
        end_y_reg <= end_y_next;
        adx_reg   <= adx_next;
        ady_reg   <= ady_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        err_reg   <= err_next;
        if (step_busy)
        begin
            pix_x_reg      <= cur_x_reg;
            pix_y_reg      <= cur_y_reg;
            pix_color_reg  <= color_reg;
            pix_inside_reg <= inside_now;
            pix_last_reg   <= shape_done;
        end
    end

    assign pix.valid       = pix_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.inside_res  = pix_inside_reg;
    assign pix.last        = pix_last_reg;

`ifndef SYNTHESIS
    // A start never produces a pixel of its own.
    a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && is_start |=> !pix_valid_reg)
        else $error("start command produced a pixel");

    // A step with no active shape produces nothing.
    a_idle_step_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && !is_start && !busy_reg |=> !pix_valid_reg)
        else $error("step while idle produced a pixel");

    // The final pixel of a shape leaves the core idle.
    a_last_ends_shape: assert property (@(posedge clk) disable iff (!rst_n)
        $past(step_busy) && pix_last_reg |-> !busy_reg)
        else $error("last pixel emitted while shape still active");
`endif

endmodule
